// ===== hdl/assert_macros.svh =====
// Assertion macros used by request_tag_allocator_core of the request tag allocator.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/rta_pkg.sv =====
// Package of the request tag allocator: opcodes, status codes, mark words and sequencer states.
// Depends on nothing; used by request_tag_allocator_core.
`default_nettype none

package rta_pkg;

  localparam logic [1:0] OPC_ALLOC = 2'd0;
  localparam logic [1:0] OPC_SET   = 2'd1;
  localparam logic [1:0] OPC_GET   = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_NO_FREE     = 2'd1;
  localparam logic [1:0] STAT_NOT_PENDING = 2'd2;
  localparam logic [1:0] STAT_NOT_READY   = 2'd3;

  // Mark memory word: bit 1 is pending, bit 0 is arrived.
  localparam logic [1:0] MARK_CLEAR   = 2'b00;
  localparam logic [1:0] MARK_GRANTED = 2'b10;
  localparam logic [1:0] MARK_ARRIVED = 2'b11;
  localparam logic [1:0] MARK_DONE    = 2'b01;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_CHECK
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/request_tag_allocator_core.sv =====
// Top level of the request tag allocator: sequencer, mark memory and response memory.
// Depends on rta_pkg and assert_macros.svh.
//
//   Channel   Signals                                        Handshake
//   request   start, busy, opcode_i, slot_id_i,              start && !busy
//             response_data_i
//   result    done_o, status_o, granted_id_o, read_data_o    done_o, one cycle
//   config    cfg_we_i, cfg_wdata_i (id_limit)               cfg_we_i
//
// An unused opcode, or a set or get on a tag outside the table, gives its result in the
// cycle after the item is accepted. Set and get pass through the access and check states.
// An allocate visits the access and check states once per tag examined (at most the
// active size); the mark memory has one read port and the search reads one tag per visit.
// After reset a clearing pass writes every word of the mark memory with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

`include "assert_macros.svh"

module request_tag_allocator_core #(
  parameter int DEPTH      = 64,
  parameter int GROW_STEP  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [5:0]  slot_id_i,
  input  wire logic [31:0] response_data_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [5:0]       granted_id_o,
  output logic [31:0]      read_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 2 * GROW_STEP + 1);

  rta_pkg::state_e state_q, state_d;

  logic [1:0]            op_q, op_d;
  logic [DATA_WIDTH-1:0] wdata_q, wdata_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [AW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         search_q, search_d;
  logic [SW-1:0]         active_q, active_d;
  logic [15:0]           idlim_q;
  logic                  done_q, done_d;
  logic [1:0]            status_q, status_d;
  logic [5:0]            granted_q, granted_d;
  logic [31:0]           rdata_q, rdata_d;

  logic [1:0]            marks_mem [DEPTH];
  logic [DATA_WIDTH-1:0] data_mem [DEPTH];
  logic [1:0]            marks_rd_q;
  logic [DATA_WIDTH-1:0] data_rd_q;
  logic                  marks_we;
  logic [AW-1:0]         marks_wa;
  logic [1:0]            marks_wd;
  logic                  data_we;

  logic          accept;
  logic          in_table;
  logic          clear_last;
  logic [SW-1:0] eff;
  logic [AW-1:0] addr_next;
  logic          scan_last;
  logic          scan_more;
  logic [SW-1:0] grown;
  logic          grow_fail;

  assign accept     = start && !busy;
  assign busy       = (state_q != rta_pkg::S_IDLE);
  assign in_table   = (32'(slot_id_i) < 32'(DEPTH));
  assign clear_last = (addr_q == AW'(DEPTH - 1));
  assign eff        = (active_q > SW'(DEPTH)) ? SW'(DEPTH) : active_q;
  assign addr_next  = ((SW'(addr_q) + SW'(1)) == eff) ? '0 : addr_q + AW'(1);
  assign scan_last  = (SW'(cnt_q) == (eff - SW'(1)));
  assign scan_more  = (op_q == rta_pkg::OPC_ALLOC) && marks_rd_q[1] && !scan_last;
  assign grown      = active_q + SW'(GROW_STEP);
  assign grow_fail  = (32'(grown) >= 32'(idlim_q)) || (grown > SW'(DEPTH));

  always_comb begin
    state_d = state_q;
    case (state_q)
      rta_pkg::S_CLEAR: begin
        if (clear_last) begin
          state_d = rta_pkg::S_IDLE;
        end
      end
      rta_pkg::S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            rta_pkg::OPC_ALLOC: state_d = rta_pkg::S_ACCESS;
            rta_pkg::OPC_SET,
            rta_pkg::OPC_GET: begin
              if (in_table) begin
                state_d = rta_pkg::S_ACCESS;
              end
            end
            default: state_d = rta_pkg::S_IDLE;
          endcase
        end
      end
      rta_pkg::S_ACCESS: state_d = rta_pkg::S_CHECK;
      rta_pkg::S_CHECK: begin
        state_d = scan_more ? rta_pkg::S_ACCESS : rta_pkg::S_IDLE;
      end
      default: state_d = rta_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    op_d      = op_q;
    wdata_d   = wdata_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    search_d  = search_q;
    active_d  = active_q;
    done_d    = 1'b0;
    status_d  = status_q;
    granted_d = granted_q;
    rdata_d   = rdata_q;
    marks_we  = 1'b0;
    marks_wa  = addr_q;
    marks_wd  = rta_pkg::MARK_CLEAR;
    data_we   = 1'b0;
    case (state_q)
      rta_pkg::S_CLEAR: begin
        marks_we = 1'b1;
        addr_d   = clear_last ? '0 : addr_q + AW'(1);
      end
      rta_pkg::S_IDLE: begin
        if (accept) begin
          op_d      = opcode_i;
          wdata_d   = DATA_WIDTH'(response_data_i);
          cnt_d     = '0;
          status_d  = rta_pkg::STAT_OK;
          granted_d = '0;
          rdata_d   = '0;
          case (opcode_i)
            rta_pkg::OPC_ALLOC: addr_d = search_q;
            rta_pkg::OPC_SET: begin
              addr_d = AW'(slot_id_i);
              if (!in_table) begin
                done_d   = 1'b1;
                status_d = rta_pkg::STAT_NOT_PENDING;
              end
            end
            rta_pkg::OPC_GET: begin
              addr_d = AW'(slot_id_i);
              if (!in_table) begin
                done_d   = 1'b1;
                status_d = rta_pkg::STAT_NOT_READY;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      rta_pkg::S_CHECK: begin
        case (op_q)
          rta_pkg::OPC_ALLOC: begin
            if (!marks_rd_q[1]) begin
              done_d    = 1'b1;
              marks_we  = 1'b1;
              marks_wd  = rta_pkg::MARK_GRANTED;
              granted_d = 6'(addr_q);
              search_d  = addr_next;
            end else if (scan_last) begin
              done_d = 1'b1;
              if (grow_fail) begin
                status_d = rta_pkg::STAT_NO_FREE;
              end else begin
                marks_we  = 1'b1;
                marks_wa  = AW'(active_q);
                marks_wd  = rta_pkg::MARK_GRANTED;
                granted_d = 6'(active_q);
                active_d  = grown;
                search_d  = ((active_q + SW'(1)) == grown) ? '0 : AW'(active_q + SW'(1));
              end
            end else begin
              cnt_d  = cnt_q + AW'(1);
              addr_d = addr_next;
            end
          end
          rta_pkg::OPC_SET: begin
            done_d = 1'b1;
            if (marks_rd_q[1]) begin
              data_we  = 1'b1;
              marks_we = 1'b1;
              marks_wd = rta_pkg::MARK_ARRIVED;
            end else begin
              status_d = rta_pkg::STAT_NOT_PENDING;
            end
          end
          rta_pkg::OPC_GET: begin
            done_d = 1'b1;
            if (marks_rd_q[0]) begin
              rdata_d  = 32'(data_rd_q);
              marks_we = 1'b1;
              marks_wd = rta_pkg::MARK_DONE;
            end else begin
              status_d = rta_pkg::STAT_NOT_READY;
            end
          end
          default: done_d = 1'b1;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rta_pkg::S_CLEAR;
      addr_q   <= '0;
      cnt_q    <= '0;
      op_q     <= rta_pkg::OPC_ALLOC;
      search_q <= '0;
      active_q <= SW'(GROW_STEP);
      idlim_q  <= 16'd64;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      cnt_q    <= cnt_d;
      op_q     <= op_d;
      search_q <= search_d;
      active_q <= active_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        idlim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wdata_q   <= wdata_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    rdata_q   <= rdata_d;
  end

  always_ff @(posedge clk_i) begin
    if (marks_we) begin
      marks_mem[marks_wa] <= marks_wd;
    end
    marks_rd_q <= marks_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[addr_q] <= wdata_q;
    end
    data_rd_q <= data_mem[addr_q];
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign granted_id_o = granted_q;
  assign read_data_o  = rdata_q;

  `RTA_ASSERT(a_accept_progress, accept |=> (done_o || busy), "accepted item neither finished nor in progress")
  `RTA_ASSERT(a_search_in_range, (state_q == rta_pkg::S_IDLE) |-> (SW'(search_q) < eff), "search pointer outside the active table")
  `RTA_ASSERT(a_fail_zero_payload, (done_o && (status_o != rta_pkg::STAT_OK)) |-> ((granted_id_o == 6'd0) && (read_data_o == 32'd0)), "failed item carries a nonzero payload")
  `RTA_ASSERT(a_active_grows, 1'b1 |=> (active_q >= $past(active_q)), "active size shrank")

endmodule

`default_nettype wire
